>>> rtl/trajectory_linear_interpolator_macros.svh
// Assertion macros for the trajectory interpolator checker.
// No dependencies; expects clk and rst_n in the scope of use.
`ifndef TRAJECTORY_LINEAR_INTERPOLATOR_MACROS_SVH
`define TRAJECTORY_LINEAR_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TLI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define TLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/tli_pkg.sv
// Package for the trajectory interpolator: command types, FSM states, widths.
// No dependencies.
`default_nettype none
package tli_pkg;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 48;
  localparam int QBITS      = 40;  // quotient saturates at 2^QBITS
  localparam int QDEPTH     = 4;

  localparam logic CFG_POINT_COUNT = 1'b0;
  localparam logic CFG_JOINT_COUNT = 1'b1;

  typedef enum logic [1:0] {
    KIND_TIME  = 2'd0,
    KIND_JOINT = 2'd1,
    KIND_PLAY  = 2'd2,
    KIND_TICK  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [5:0]  pidx;
    logic [2:0]  jidx;
    logic [31:0] tval;
    logic [31:0] jval;
    logic        run;
    logic        wr_ok;   // table address within range
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_if_t;

  typedef struct packed {
    logic        done;
    logic [QBITS:0] quot;
  } div_res_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_UP_RD, ST_UP_CMP, ST_DN_RD, ST_DN_CMP, ST_CHK_RD, ST_CHK_CMP,
    ST_T0_RD, ST_T1_RD, ST_T1_CAP, ST_J0_RD, ST_J1_RD, ST_J1_CAP,
    ST_CALC, ST_MUL, ST_DIV_GO, ST_DIV_WAIT, ST_EMIT, ST_NULL
  } state_t;

endpackage
`default_nettype wire

>>> rtl/tli_ram.sv
// Generic simple dual-port RAM, registered read.
// No dependencies.
`default_nettype none
module tli_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata_r
);
  logic [W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/tli_front.sv
// Front end: takes input transfers, decodes them into commands, small queue.
// Depends on tli_pkg.
`default_nettype none
module tli_front import tli_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_JOINTS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic [1:0]           in_tuser,
  input  wire logic                 pop,
  output q_if_t                     q
);
  localparam int CW = $clog2(QDEPTH + 1);
  localparam int PTW = $clog2(QDEPTH);

  cmd_t           mem_r [QDEPTH];
  logic [PTW-1:0] wr_r, rd_r;
  logic [CW-1:0]  cnt_r;
  cmd_t           dec;
  logic           push;

  always_comb begin
    dec.kind  = kind_t'(in_tuser);
    dec.pidx  = in_tdata[5:0];
    dec.jidx  = in_tdata[8:6];
    dec.tval  = in_tdata[40:9];
    dec.jval  = in_tdata[72:41];
    dec.run   = in_tdata[73];
    dec.wr_ok = (32'(dec.pidx) < MAX_POINTS) &&
                ((dec.kind != KIND_JOINT) || (32'(dec.jidx) < MAX_JOINTS));
  end

  assign in_tready = (32'(cnt_r) != QDEPTH);
  assign push      = in_tvalid && in_tready;
  assign q.valid   = (cnt_r != '0);
  assign q.cmd     = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= dec;
    end
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end
endmodule
`default_nettype wire

>>> rtl/tli_div.sv
// Restoring divider, one quotient bit a cycle, quotient saturated at 2^QBITS.
// Depends on tli_pkg.
`default_nettype none
module tli_div import tli_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output div_res_t         res
);
  logic [31:0]      rem_r;
  logic [QBITS-1:0] num_r;
  logic [QBITS:0]   quot_r;
  logic [5:0]       cnt_r;
  logic             busy_r, done_r;
  logic [32:0]      rs;
  logic             qbit;
  logic             sat;

  assign rs   = {rem_r, num_r[QBITS-1]};
  assign qbit = (rs >= {1'b0, divisor});
  assign sat  = ({8'd0, dividend} >= {divisor, {QBITS{1'b0}}});
  assign res.done = done_r;
  assign res.quot = quot_r;

  always_ff @(posedge clk) begin
    if (start) begin
      if (sat) begin
        quot_r <= {1'b1, {QBITS{1'b0}}};
      end else begin
        rem_r  <= 32'(dividend[63:QBITS]);
        num_r  <= dividend[QBITS-1:0];
        quot_r <= '0;
      end
    end else if (busy_r) begin
      rem_r  <= qbit ? 32'(rs - {1'b0, divisor}) : rs[31:0];
      num_r  <= {num_r[QBITS-2:0], 1'b0};
      quot_r <= {quot_r[QBITS-1:0], qbit};
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= start ? sat : (busy_r && (cnt_r == 6'd1));
      if (start) begin
        if (!sat) begin
          busy_r <= 1'b1;
          cnt_r  <= 6'(QBITS);
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/tli_back.sv
// Back end: executes commands, owns the tables, segment search and interpolation.
// Depends on tli_pkg, tli_ram, tli_div.
`default_nettype none
module tli_back import tli_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_JOINTS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  q_if_t                      q,
  output logic                       pop,
  input  wire logic [6:0]            point_count,
  input  wire logic [3:0]            joint_count,
  input  wire logic                  out_tready,
  output logic                       out_tvalid,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [0:0]                 out_tuser,
  output logic                       out_tlast
);
  localparam int PW  = $clog2(MAX_POINTS);
  localparam int SW  = $clog2(MAX_POINTS + 1);
  localparam int JW  = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int JCW = $clog2(MAX_JOINTS + 1);
  localparam int JAW = PW + JW;

  state_t state_r, state_nxt;

  logic [SW-1:0]  idx_r, n_r, n_now;
  logic [JCW-1:0] jc_r, jc_now;
  logic [JW-1:0]  k_r;
  logic [31:0]    cur_r, step_r, t0_r, t1_r, v0_r, v1_r;
  logic [31:0]    dxm_r, dvm_r, denm_r;
  logic           neg_r, dz_r, run_r;
  logic [63:0]    prod_r;

  logic           out_valid_r, out_vv_r, out_play_r, out_last_r;
  logic [2:0]     out_jid_r;
  logic [31:0]    out_res_r;
  logic [6:0]     out_seg_r;

  logic           tm_we, jt_we, div_start, slot_free, is_last, seg_in, out_set;
  logic [PW-1:0]  tm_raddr;
  logic [JAW-1:0] jt_raddr;
  logic [31:0]    tm_rdata, jt_rdata, cur_sum, ival;
  logic [32:0]    dx, dv, den, sum33;
  logic [QBITS+1:0] acc;
  div_res_t       div_o;

  tli_ram #(.W(32), .DEPTH(MAX_POINTS), .AW(PW)) u_tm (
    .clk(clk), .we(tm_we), .waddr(PW'(q.cmd.pidx)), .wdata(q.cmd.tval),
    .raddr(tm_raddr), .rdata_r(tm_rdata)
  );

  tli_ram #(.W(32), .DEPTH(MAX_POINTS << JW), .AW(JAW)) u_jt (
    .clk(clk), .we(jt_we), .waddr({PW'(q.cmd.pidx), JW'(q.cmd.jidx)}),
    .wdata(q.cmd.jval), .raddr(jt_raddr), .rdata_r(jt_rdata)
  );

  tli_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(prod_r),
    .divisor(denm_r), .res(div_o)
  );

  always_comb begin
    if (32'(point_count) < 2)               n_now = SW'(2);
    else if (32'(point_count) > MAX_POINTS) n_now = SW'(MAX_POINTS);
    else                                    n_now = SW'(point_count);
    if (joint_count == 4'd0)                jc_now = JCW'(1);
    else if (32'(joint_count) > MAX_JOINTS) jc_now = JCW'(MAX_JOINTS);
    else                                    jc_now = JCW'(joint_count);
  end

  assign slot_free = !out_valid_r || out_tready;
  assign out_set   = ((state_r == ST_EMIT) || (state_r == ST_NULL)) && slot_free;
  assign is_last   = (32'(k_r) == 32'(jc_r) - 1);
  assign seg_in    = (idx_r != '0) && (idx_r < n_r);
  assign sum33     = {1'b0, cur_r} + {1'b0, step_r};
  assign cur_sum   = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];

  // Signed differences, 33 bits each
  assign dx  = {1'b0, cur_r} - {1'b0, t0_r};
  assign dv  = {v1_r[31], v1_r} - {v0_r[31], v0_r};
  assign den = {1'b0, t1_r} - {1'b0, t0_r};

  always_comb begin
    acc = {{(QBITS - 30){v0_r[31]}}, v0_r} +
          (neg_r ? -{1'b0, div_o.quot} : {1'b0, div_o.quot});
    if (dz_r)                                        ival = v1_r;
    else if (!acc[QBITS+1] && (acc[QBITS:31] != '0)) ival = 32'h7FFF_FFFF;
    else if (acc[QBITS+1] && (acc[QBITS:31] != '1))  ival = 32'h8000_0000;
    else                                             ival = acc[31:0];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (q.valid && q.cmd.kind == KIND_TICK) state_nxt = ST_UP_RD;
      ST_UP_RD:    state_nxt = (idx_r < n_r) ? ST_UP_CMP : ST_DN_RD;
      ST_UP_CMP:   state_nxt = (cur_r > tm_rdata) ? ST_UP_RD : ST_DN_RD;
      ST_DN_RD:    state_nxt = (idx_r != '0) ? ST_DN_CMP : ST_CHK_RD;
      ST_DN_CMP:   state_nxt = (cur_r < tm_rdata) ? ST_DN_RD : ST_CHK_RD;
      ST_CHK_RD:   state_nxt = ST_CHK_CMP;
      ST_CHK_CMP:  state_nxt = (run_r && cur_r < tm_rdata && seg_in) ? ST_T0_RD : ST_NULL;
      ST_T0_RD:    state_nxt = ST_T1_RD;
      ST_T1_RD:    state_nxt = ST_T1_CAP;
      ST_T1_CAP:   state_nxt = ST_J0_RD;
      ST_J0_RD:    state_nxt = ST_J1_RD;
      ST_J1_RD:    state_nxt = ST_J1_CAP;
      ST_J1_CAP:   state_nxt = ST_CALC;
      ST_CALC:     state_nxt = ST_MUL;
      ST_MUL:      state_nxt = ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_o.done) state_nxt = ST_EMIT;
      ST_EMIT:     if (slot_free) state_nxt = is_last ? ST_IDLE : ST_J0_RD;
      ST_NULL:     if (slot_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop       = 1'b0;
    tm_we     = 1'b0;
    jt_we     = 1'b0;
    div_start = 1'b0;
    tm_raddr  = '0;
    jt_raddr  = '0;
    case (state_r)
      ST_IDLE: begin
        pop   = q.valid;
        tm_we = q.valid && q.cmd.kind == KIND_TIME && q.cmd.wr_ok;
        jt_we = q.valid && q.cmd.kind == KIND_JOINT && q.cmd.wr_ok;
      end
      ST_UP_RD:  tm_raddr = PW'(idx_r);
      ST_DN_RD:  tm_raddr = PW'(idx_r - 1'b1);
      ST_CHK_RD: tm_raddr = PW'(n_r - 1'b1);
      ST_T0_RD:  tm_raddr = PW'(idx_r - 1'b1);
      ST_T1_RD:  tm_raddr = PW'(idx_r);
      ST_J0_RD:  jt_raddr = {PW'(idx_r - 1'b1), k_r};
      ST_J1_RD:  jt_raddr = {PW'(idx_r), k_r};
      ST_DIV_GO: div_start = 1'b1;
      default: begin
      end
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE:   if (q.valid && q.cmd.kind == KIND_TICK) begin
        step_r <= q.cmd.tval;
        n_r    <= n_now;
        jc_r   <= jc_now;
      end
      ST_T1_RD:  t0_r <= tm_rdata;
      ST_T1_CAP: t1_r <= tm_rdata;
      ST_J1_RD:  v0_r <= jt_rdata;
      ST_J1_CAP: v1_r <= jt_rdata;
      ST_CALC: begin
        dxm_r  <= dx[32] ? 32'(-dx) : dx[31:0];
        dvm_r  <= dv[32] ? 32'(-dv) : dv[31:0];
        denm_r <= den[32] ? 32'(-den) : den[31:0];
        neg_r  <= dx[32] ^ dv[32] ^ den[32];
        dz_r   <= (den == '0);
      end
      ST_MUL:    prod_r <= dxm_r * dvm_r;
      default: begin
      end
    endcase
    if (state_r == ST_EMIT && slot_free) begin
      out_jid_r  <= 3'(k_r);
      out_res_r  <= ival;
      out_vv_r   <= 1'b1;
      out_play_r <= 1'b1;
      out_seg_r  <= 7'(idx_r);
      out_last_r <= is_last;
    end else if (state_r == ST_NULL && slot_free) begin
      out_jid_r  <= '0;
      out_res_r  <= '0;
      out_vv_r   <= 1'b0;
      out_play_r <= run_r;
      out_seg_r  <= 7'(idx_r);
      out_last_r <= 1'b1;
    end
  end

  // Control and playback state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      cur_r       <= '0;
      run_r       <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_set || (out_valid_r && !out_tready);
      case (state_r)
        ST_IDLE: if (q.valid) begin
          if (q.cmd.kind == KIND_PLAY) begin
            run_r <= q.cmd.run;
            cur_r <= q.cmd.tval;
          end else if (q.cmd.kind == KIND_TICK) begin
            if (idx_r > n_now) idx_r <= n_now;
          end
        end
        ST_UP_CMP: if (cur_r > tm_rdata) idx_r <= idx_r + 1'b1;
        ST_DN_CMP: if (cur_r < tm_rdata) idx_r <= idx_r - 1'b1;
        ST_CHK_CMP: begin
          k_r <= '0;
          if (run_r && cur_r < tm_rdata) cur_r <= cur_sum;
          else                            run_r <= 1'b0;
        end
        ST_EMIT: if (slot_free && !is_last) k_r <= k_r + 1'b1;
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_seg_r, out_play_r, out_res_r, out_jid_r};
  assign out_tuser  = out_vv_r;
  assign out_tlast  = out_last_r;
endmodule
`default_nettype wire

>>> rtl/trajectory_linear_interpolator.sv
// Multi-joint piecewise-linear trajectory player, top level.
// Depends on tli_pkg, tli_front, tli_back (and through it tli_ram, tli_div).
//
// Items enter on the in_ stream and pass through a four-deep command queue
// to an executing back end, so the input keeps taking transfers while a tick
// is still being worked on. Point-time and joint-value writes and playback
// updates give no result. A tick walks the segment index to bracket the
// current time (a read and a compare state per point moved, one read port
// on the time table), checks the final point time, then, if it interpolates,
// reads the segment end times and for each joint runs two joint-table reads,
// difference and multiply stages, and a 40-step restoring divider that sets
// the pace. A tick that interpolates nothing gives one result.
// The tables are not cleared at reset; reading an unwritten entry gives
// undefined values. A stalled result holds in the output register while
// the front end keeps filling the queue. Configuration writes take effect
// on the next tick and must only be made while the block is idle.
`default_nettype none
module trajectory_linear_interpolator import tli_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_JOINTS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // fields from bit 0: point_index[5:0], joint_index[8:6], time_value[40:9],
  // joint_value[72:41], run[73], zero fill
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [1:0]            in_tuser,   // kind
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // fields from bit 0: joint_id[2:0], joint_result[34:3], playing[35],
  // segment[42:36], zero fill
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [0:0]                 out_tuser,  // value_valid
  output logic                       out_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic                  cfg_wr_en,
  input  wire logic                  cfg_addr,
  input  wire logic [6:0]            cfg_wdata
);
  logic [6:0] point_count_r;
  logic [3:0] joint_count_r;
  q_if_t      q;
  logic       pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= 7'd2;
      joint_count_r <= 4'd1;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_POINT_COUNT: point_count_r <= cfg_wdata;
        CFG_JOINT_COUNT: joint_count_r <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  tli_front #(.MAX_POINTS(MAX_POINTS), .MAX_JOINTS(MAX_JOINTS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .pop(pop), .q(q)
  );

  tli_back #(.MAX_POINTS(MAX_POINTS), .MAX_JOINTS(MAX_JOINTS)) u_back (
    .clk(clk), .rst_n(rst_n), .q(q), .pop(pop),
    .point_count(point_count_r), .joint_count(joint_count_r),
    .out_tready(out_tready), .out_tvalid(out_tvalid), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );
endmodule
`default_nettype wire

>>> rtl/tli_chk.sv
// Port-level checker for the trajectory interpolator, bound to the top level.
// Depends on tli_pkg and trajectory_linear_interpolator_macros.svh.
`default_nettype none
`include "trajectory_linear_interpolator_macros.svh"
module tli_chk import tli_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic [IN_DATA_W-1:0]  in_tdata,
  input wire logic [1:0]            in_tuser,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [0:0]            out_tuser,
  input wire logic                  out_tlast,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic                  cfg_wr_en,
  input wire logic                  cfg_addr,
  input wire logic [6:0]            cfg_wdata
);
  `TLI_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "result changed while stalled")
  `TLI_ASSERT_NOW(a_null_last, out_tvalid && !out_tuser[0], out_tlast, "result without value must end the tick")
  `TLI_ASSERT_NOW(a_null_zero, out_tvalid && !out_tuser[0], out_tdata[34:0] == 35'd0, "result without value carries data")
  `TLI_ASSERT_NOW(a_val_play, out_tvalid && out_tuser[0], out_tdata[35], "value given while not playing")
endmodule

bind trajectory_linear_interpolator tli_chk u_chk (.*);
`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for trajectory_linear_interpolator: table loads, playback
// control and ticks, checked against an in-bench Q16.16 interpolation predictor.
// Depends on tli_pkg and the RTL of the block only.
`timescale 1ns / 100ps
module testbench;
  import tli_pkg::*;

  // expected content of one result transfer
  typedef struct {
    bit [2:0]  joint_id;
    bit [31:0] joint_val;
    bit        fresh;      // value_valid
    bit        playing;
    bit [6:0]  segment;
    bit        tail;       // tlast
  } joint_sample_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = KIND_TIME;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic                  cfg_addr = CFG_POINT_COUNT;
  logic [6:0]            cfg_wdata = '0;

  trajectory_linear_interpolator DUT (.*);

  always #5 clk = ~clk;

  // predictor state
  bit [31:0]     pt_time [64];
  bit [31:0]     pt_joint [64][8];
  bit [31:0]     play_time;
  bit [6:0]      seg_idx;
  bit            play_on;
  bit [6:0]      reg_points = 7'd2;
  bit [3:0]      reg_joints = 4'd1;
  joint_sample_t pending_joints[$];
  int            err_count = 0;
  int            send_idle = 21;   // percent of items after which the sender holds off
  int            recv_idle = 64;   // percent of cycles the receiver stalls

  function automatic int points_in_use();
    if (reg_points < 2) return 2;
    if (reg_points > 64) return 64;
    return reg_points;
  endfunction

  function automatic int joints_in_use();
    if (reg_joints < 1) return 1;
    if (reg_joints > 8) return 8;
    return reg_joints;
  endfunction

  function automatic longint magn(longint v);
    return v < 0 ? -v : v;
  endfunction

  // append one expected result at the tail of the queue
  function automatic void add_expected(joint_sample_t s);
    pending_joints = {pending_joints, s};
  endfunction

  // value at time t on the line through (t0,v0) and (t1,v1), saturated; v1 if t1 == t0
  function automatic bit [31:0] lerp_joint(bit [31:0] t, bit [31:0] t0, bit [31:0] t1,
                                           bit [31:0] v0u, bit [31:0] v1u);
    longint    v0, dx, dv, den, res;
    bit [127:0] quo;
    bit        neg;
    v0  = longint'($signed(v0u));
    dx  = longint'(t) - longint'(t0);
    dv  = longint'($signed(v1u)) - v0;
    den = longint'(t1) - longint'(t0);
    if (den == 0) return v1u;
    quo = (128'(magn(dx)) * 128'(magn(dv))) / 128'(magn(den));
    if (quo >= (128'd1 << QBITS)) quo = 128'd1 << QBITS;
    if (dx == 0 || dv == 0) quo = 0;
    neg = ((dx < 0) != (dv < 0)) != (den < 0);
    res = neg ? v0 - longint'(quo) : v0 + longint'(quo);
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res[31:0];
  endfunction

  // segment search, time advance and joint outputs of one tick
  task automatic predict_tick(bit [31:0] step);
    int            n, jc, idx;
    bit [32:0]     sum;
    joint_sample_t s;
    n   = points_in_use();
    jc  = joints_in_use();
    idx = seg_idx;
    if (idx > n) idx = n;
    while (idx < n && play_time > pt_time[idx]) idx++;
    while (idx > 0 && play_time < pt_time[idx-1]) idx--;
    seg_idx = 7'(idx);
    if (play_on && play_time < pt_time[n-1]) begin
      sum = {1'b0, play_time} + step;
      play_time = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      if (idx > 0 && idx < n) begin
        for (int k = 0; k < jc; k++) begin
          s.joint_id  = 3'(k);
          s.joint_val = lerp_joint(play_time, pt_time[idx-1], pt_time[idx],
                                   pt_joint[idx-1][k], pt_joint[idx][k]);
          s.fresh     = 1'b1;
          s.playing   = 1'b1;
          s.segment   = 7'(idx);
          s.tail      = (k + 1 == jc);
          add_expected(s);
        end
        return;
      end
    end else begin
      play_on = 1'b0;
    end
    s = '{joint_id: 0, joint_val: 0, fresh: 0, playing: play_on, segment: 7'(idx), tail: 1};
    add_expected(s);
  endtask

  // one input transfer; the model state moves at acceptance
  task automatic send_item(kind_t k, bit [5:0] p, bit [2:0] j, bit [31:0] tv,
                           bit [31:0] jv, bit r);
    in_tuser  <= k;
    in_tdata  <= {6'b0, r, jv, tv, j, p};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    case (k)
      KIND_TIME:  pt_time[p] = tv;
      KIND_JOINT: pt_joint[p][j] = jv;
      KIND_PLAY: begin
        play_on   = r;
        play_time = tv;
      end
      default:    predict_tick(tv);
    endcase
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // drain, let queued table writes finish, then write both registers
  task automatic set_registers(bit [6:0] points, bit [6:0] joints);
    in_tvalid <= 1'b0;
    while (pending_joints.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= CFG_POINT_COUNT;
    cfg_wdata <= points;
    @(posedge clk);
    cfg_addr  <= CFG_JOINT_COUNT;
    cfg_wdata <= joints;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    reg_points = points;
    reg_joints = joints[3:0];
  endtask

  // result checker
  always @(posedge clk) begin
    joint_sample_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_joints.size() == 0) begin
        $display("%0t: unexpected result transfer %h", $time, out_tdata);
        err_count++;
      end else begin
        e = pending_joints.pop_front();
        if (out_tdata[2:0] !== e.joint_id || out_tdata[34:3] !== e.joint_val ||
            out_tuser[0] !== e.fresh || out_tdata[35] !== e.playing ||
            out_tdata[42:36] !== e.segment || out_tlast !== e.tail) begin
          $display("%0t: expected id %0d val %h vv %b play %b seg %0d last %b, got %0d %h %b %b %0d %b",
                   $time, e.joint_id, e.joint_val, e.fresh, e.playing, e.segment, e.tail,
                   out_tdata[2:0], out_tdata[34:3], out_tuser[0], out_tdata[35],
                   out_tdata[42:36], out_tlast);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle);

  // saturation on both ends, stop at final time, time overflow, equal bracket times
  task automatic test_directed();
    send_item(KIND_TIME, 0, 0, 32'h0, 0, 0);
    send_item(KIND_TIME, 1, 0, 32'h1_0000, 0, 0);
    send_item(KIND_JOINT, 0, 0, 0, 32'h7FFF_FFFF, 0);
    send_item(KIND_JOINT, 1, 0, 0, 32'h8000_0000, 0);
    send_item(KIND_TICK, 0, 0, 32'h100, 0, 0);           // stopped: null result
    send_item(KIND_PLAY, 0, 0, 32'h0, 0, 1);
    send_item(KIND_TICK, 0, 0, 32'h8000, 0, 0);          // segment 0: null, still playing
    send_item(KIND_TICK, 0, 0, 32'h8000, 0, 0);
    send_item(KIND_TICK, 0, 0, 32'h1000, 0, 0);          // at final time: stops
    send_item(KIND_PLAY, 0, 0, 32'h4000, 0, 1);
    send_item(KIND_TICK, 0, 0, 32'hFFFF_FFFF, 0, 0);     // time saturates, value clips
    set_registers(7'd4, 7'd2);
    send_item(KIND_TIME, 2, 0, 32'h2_0000, 0, 0);
    send_item(KIND_TIME, 3, 0, 32'h3_0000, 0, 0);
    send_item(KIND_JOINT, 0, 1, 0, 32'hFFFF_0000, 0);
    send_item(KIND_JOINT, 1, 1, 0, 32'h0003_0000, 0);
    send_item(KIND_JOINT, 2, 0, 0, 32'h0001_8000, 0);
    send_item(KIND_JOINT, 2, 1, 0, 32'hFFFF_FFFF, 0);
    send_item(KIND_JOINT, 3, 0, 0, 32'h0, 0);
    send_item(KIND_JOINT, 3, 1, 0, 32'h7FFF_0000, 0);
    send_item(KIND_PLAY, 0, 0, 32'h1_8000, 0, 1);
    send_item(KIND_TICK, 0, 0, 32'h0, 0, 0);             // lands in segment 2
    send_item(KIND_TIME, 1, 0, 32'h2_0000, 0, 0);        // now t1 == t2
    send_item(KIND_PLAY, 0, 0, 32'h2_0000, 0, 1);
    send_item(KIND_TICK, 0, 0, 32'h100, 0, 0);
  endtask

  // load the tables for the setting, then a mix biased towards playing ticks
  task automatic test_phase(bit [6:0] points, bit [6:0] joints, int ops, bit wide);
    int        n, jc, sel;
    bit [31:0] t, lo, hi, span;
    bit [32:0] nxt;
    set_registers(points, joints);
    n  = points_in_use();
    jc = joints_in_use();
    t  = wide ? $urandom : $urandom_range(0, 32'hF_FFFF);
    for (int p = 0; p < n; p++) begin
      send_item(KIND_TIME, 6'(p), 3'($urandom), t, $urandom, 1'($urandom));
      nxt = {1'b0, t} + ($urandom_range(9) == 0 ? 32'h0 :
                         wide ? $urandom_range(0, 32'h3FF_FFFF) : $urandom_range(1, 32'h3_FFFF));
      t = nxt[32] ? 32'hFFFF_FFFF : nxt[31:0];
    end
    for (int p = 0; p < n; p++)
      for (int k = 0; k < jc; k++)
        send_item(KIND_JOINT, 6'(p), 3'(k), $urandom,
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 32'h3F_FFFF) - 32'h1F_FFFF,
                  1'($urandom));
    for (int i = 0; i < ops; i++) begin
      lo   = pt_time[0] < pt_time[n-1] ? pt_time[0] : pt_time[n-1];
      hi   = pt_time[0] < pt_time[n-1] ? pt_time[n-1] : pt_time[0];
      span = hi - lo;
      sel  = $urandom_range(99);
      if (sel < 60)
        send_item(KIND_TICK, 6'($urandom), 3'($urandom),
                  $urandom_range(15) == 0 ? $urandom : $urandom_range(0, span / 8 + 1),
                  $urandom, 1'($urandom));
      else if (sel < 78)
        send_item(KIND_PLAY, 6'($urandom), 3'($urandom),
                  $urandom_range(4) == 0 ? $urandom : $urandom_range(lo, hi),
                  $urandom, $urandom_range(5) != 0);
      else if (sel < 90)
        send_item(KIND_JOINT, 6'($urandom), 3'($urandom), $urandom, $urandom,
                  1'($urandom));
      else
        send_item(KIND_TIME, 6'($urandom), 3'($urandom),
                  $urandom_range(1) ? $urandom : $urandom_range(lo, hi), $urandom,
                  1'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_phase(7'd2, 7'd1, 16, 0);
    test_phase(7'd5, 7'd3, 16, 0);
    send_idle = 64;
    recv_idle = 21;
    test_phase(7'd0, 7'h70, 16, 1);        // both counts below range
    test_phase(7'd127, 7'd1, 16, 0);       // point count above range
    send_idle = 0;
    recv_idle = 0;
    test_phase(7'd3, 7'h7F, 16, 0);        // joint count above range
    test_phase(7'd6, 7'd2, 16, 1);
    in_tvalid <= 1'b0;
    while (pending_joints.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
